// File: rtl/bss_pkg.sv
// Shared types and constants for the boot-strap reset sequencer.
`default_nettype none

package bss_pkg;

  localparam int unsigned TickW   = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned NumChan = 5;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // Register defaults after reset.
  localparam logic [TickW-1:0] PollDefault        = 10'd50;
  localparam logic [TickW-1:0] DebounceDefault    = 10'd50;
  localparam logic [TickW-1:0] EnLowDefault       = 10'd10;
  localparam logic [TickW-1:0] StrapHoldDefault   = 10'd250;
  localparam logic [TickW-1:0] StrapAfterDefault  = 10'd100;
  localparam logic [TickW-1:0] ReleasePollDefault = 10'd100;
  localparam logic [TickW-1:0] SettleDefault      = 10'd200;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLL         = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_EN_LOW       = 3'd2,
    REG_STRAP_HOLD   = 3'd3,
    REG_STRAP_AFTER  = 3'd4,
    REG_RELEASE_POLL = 3'd5,
    REG_SETTLE       = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    REQ_NONE     = 3'd0,
    REQ_OTA      = 3'd1,
    REQ_FACTORY  = 3'd2,
    REQ_PROV     = 3'd3,
    REQ_SELF_OTA = 3'd4
  } req_code_t;

  // Channel numbers, also the bit positions in the pending mask.
  localparam logic [ChanW-1:0] ChOta     = 3'd0;
  localparam logic [ChanW-1:0] ChFactory = 3'd1;
  localparam logic [ChanW-1:0] ChProv    = 3'd2;
  localparam logic [ChanW-1:0] ChBoot    = 3'd3;
  localparam logic [ChanW-1:0] ChSelfOta = 3'd4;

  typedef struct packed {
    logic [TickW-1:0] poll_ticks;
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] en_low_ticks;
    logic [TickW-1:0] strap_hold_ticks;
    logic [TickW-1:0] strap_after_ticks;
    logic [TickW-1:0] release_poll_ticks;
    logic [TickW-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic ota_pin;
    logic factory_pin;
    logic prov_pin;
    logic boot_pin;
    logic self_ota_pin;
  } in_data_t;

  typedef struct packed {
    logic       enable_out;
    logic       strap_out;
    logic [2:0] request_code;
    logic       busy_res;
  } out_data_t;

endpackage

`default_nettype wire

// File: rtl/bss_cfg_regs.sv
// Configuration register file for the boot-strap reset sequencer.
`default_nettype none

module bss_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [bss_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bss_pkg::TickW-1:0]   cfg_wdata,
  output bss_pkg::cfg_t                    cfg
);

  bss_pkg::cfg_t cfg_r;
  bss_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bss_pkg::REG_POLL:         cfg_nxt.poll_ticks         = cfg_wdata;
        bss_pkg::REG_DEBOUNCE:     cfg_nxt.debounce_ticks     = cfg_wdata;
        bss_pkg::REG_EN_LOW:       cfg_nxt.en_low_ticks       = cfg_wdata;
        bss_pkg::REG_STRAP_HOLD:   cfg_nxt.strap_hold_ticks   = cfg_wdata;
        bss_pkg::REG_STRAP_AFTER:  cfg_nxt.strap_after_ticks  = cfg_wdata;
        bss_pkg::REG_RELEASE_POLL: cfg_nxt.release_poll_ticks = cfg_wdata;
        bss_pkg::REG_SETTLE:       cfg_nxt.settle_ticks       = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_ticks         <= bss_pkg::PollDefault;
      cfg_r.debounce_ticks     <= bss_pkg::DebounceDefault;
      cfg_r.en_low_ticks       <= bss_pkg::EnLowDefault;
      cfg_r.strap_hold_ticks   <= bss_pkg::StrapHoldDefault;
      cfg_r.strap_after_ticks  <= bss_pkg::StrapAfterDefault;
      cfg_r.release_poll_ticks <= bss_pkg::ReleasePollDefault;
      cfg_r.settle_ticks       <= bss_pkg::SettleDefault;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/bss_seq.sv
// Phase state machine, tick counter and pin bookkeeping of the sequencer.
`default_nettype none

module bss_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire bss_pkg::in_data_t  pins_in,
  input  wire bss_pkg::cfg_t      cfg,
  output bss_pkg::out_data_t      res
);

  typedef enum logic [7:0] {
    PH_IDLE         = 8'b0000_0001,
    PH_DEBOUNCE     = 8'b0000_0010,
    PH_BOOT_EN_LOW  = 8'b0000_0100,
    PH_BOOT_HOLD    = 8'b0000_1000,
    PH_BOOT_AFTER   = 8'b0001_0000,
    PH_RELEASE_WAIT = 8'b0010_0000,
    PH_NORM_EN_LOW  = 8'b0100_0000,
    PH_SETTLE       = 8'b1000_0000
  } phase_t;

  function automatic logic [2:0] chan_code(input logic [bss_pkg::ChanW-1:0] ch);
    logic [2:0] code;
    unique case (ch)
      bss_pkg::ChOta:     code = bss_pkg::REQ_OTA;
      bss_pkg::ChFactory: code = bss_pkg::REQ_FACTORY;
      bss_pkg::ChProv:    code = bss_pkg::REQ_PROV;
      bss_pkg::ChSelfOta: code = bss_pkg::REQ_SELF_OTA;
      default:            code = bss_pkg::REQ_NONE;
    endcase
    return code;
  endfunction

  phase_t                       phase_r, phase_nxt;
  logic [bss_pkg::TickW-1:0]    tick_r, tick_nxt;
  logic [3:0]                   last_r, last_nxt;
  logic [bss_pkg::NumChan-1:0]  pend_r, pend_nxt;
  logic                         enable_r, enable_nxt;
  logic                         strap_r, strap_nxt;

  logic [bss_pkg::NumChan-1:0]  pins;
  logic [3:0]                   now_levels;
  logic [3:0]                   fell;
  logic [bss_pkg::NumChan-1:0]  pend_poll;
  logic [bss_pkg::NumChan-1:0]  pend_clr;
  logic [bss_pkg::ChanW-1:0]    ch;
  logic [bss_pkg::TickW-1:0]    tick_inc;
  logic [bss_pkg::TickW-1:0]    lim_sel;
  logic [bss_pkg::TickW-1:0]    lim;
  logic                         elapsed;
  logic [2:0]                   code;

  assign pins = {pins_in.self_ota_pin, pins_in.boot_pin, pins_in.prov_pin,
                 pins_in.factory_pin, pins_in.ota_pin};

  assign now_levels = {pins_in.self_ota_pin, pins_in.prov_pin,
                       pins_in.factory_pin, pins_in.ota_pin};
  assign fell       = last_r & ~now_levels;
  assign pend_poll  = pend_r | {fell[3], ~pins_in.boot_pin, fell[2:0]};

  // Lowest marked channel is served first; an empty mask picks channel zero.
  always_comb begin
    ch = '0;
    for (int i = bss_pkg::NumChan - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        ch = bss_pkg::ChanW'(i);
      end
    end
  end

  assign pend_clr = pend_r & ~(bss_pkg::NumChan'(1) << ch);
  assign tick_inc = (tick_r != bss_pkg::TickMax) ? tick_r + 1'b1 : tick_r;

  always_comb begin
    unique case (phase_r)
      PH_DEBOUNCE:                    lim_sel = cfg.debounce_ticks;
      PH_BOOT_EN_LOW, PH_NORM_EN_LOW: lim_sel = cfg.en_low_ticks;
      PH_BOOT_HOLD:                   lim_sel = cfg.strap_hold_ticks;
      PH_BOOT_AFTER:                  lim_sel = cfg.strap_after_ticks;
      PH_RELEASE_WAIT:                lim_sel = cfg.release_poll_ticks;
      PH_SETTLE:                      lim_sel = cfg.settle_ticks;
      default:                        lim_sel = cfg.poll_ticks;
    endcase
  end

  // A zero interval behaves as a single tick.
  assign lim     = (lim_sel == '0) ? bss_pkg::TickW'(1) : lim_sel;
  assign elapsed = (tick_inc >= lim);

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_inc;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    enable_nxt = enable_r;
    strap_nxt  = strap_r;
    code       = bss_pkg::REQ_NONE;

    unique case (phase_r)
      PH_DEBOUNCE: begin
        if (elapsed) begin
          tick_nxt = '0;
          if (!pins[ch] && ch == bss_pkg::ChBoot) begin
            enable_nxt = 1'b0;
            phase_nxt  = PH_BOOT_EN_LOW;
          end else begin
            if (!pins[ch]) begin
              code = chan_code(ch);
            end
            pend_nxt  = pend_clr;
            phase_nxt = (pend_clr != '0) ? PH_DEBOUNCE : PH_IDLE;
          end
        end
      end
      PH_BOOT_EN_LOW: begin
        if (elapsed) begin
          strap_nxt = 1'b0;
          tick_nxt  = '0;
          phase_nxt = PH_BOOT_HOLD;
        end
      end
      PH_BOOT_HOLD: begin
        if (elapsed) begin
          enable_nxt = 1'b1;
          tick_nxt   = '0;
          phase_nxt  = PH_BOOT_AFTER;
        end
      end
      PH_BOOT_AFTER, PH_RELEASE_WAIT: begin
        // The boot pin is checked when the strap is released and then on
        // every release poll until it goes high again.
        if (elapsed) begin
          tick_nxt = '0;
          if (phase_r == PH_BOOT_AFTER) begin
            strap_nxt = 1'b1;
          end
          if (!pins_in.boot_pin) begin
            phase_nxt = PH_RELEASE_WAIT;
          end else begin
            enable_nxt = 1'b0;
            phase_nxt  = PH_NORM_EN_LOW;
          end
        end
      end
      PH_NORM_EN_LOW: begin
        if (elapsed) begin
          strap_nxt  = 1'b1;
          enable_nxt = 1'b1;
          tick_nxt   = '0;
          phase_nxt  = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (elapsed) begin
          tick_nxt  = '0;
          pend_nxt  = pend_clr;
          phase_nxt = (pend_clr != '0) ? PH_DEBOUNCE : PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (elapsed) begin
          pend_nxt  = pend_poll;
          last_nxt  = now_levels;
          tick_nxt  = '0;
          phase_nxt = (pend_poll != '0) ? PH_DEBOUNCE : PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      last_r   <= '1;
      pend_r   <= '0;
      enable_r <= 1'b1;
      strap_r  <= 1'b1;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      last_r   <= last_nxt;
      pend_r   <= pend_nxt;
      enable_r <= enable_nxt;
      strap_r  <= strap_nxt;
    end
  end

  assign res.enable_out   = enable_nxt;
  assign res.strap_out    = strap_nxt;
  assign res.request_code = code;
  assign res.busy_res     = (phase_nxt != PH_IDLE);

endmodule

`default_nettype wire

// File: rtl/boot_strap_reset_sequencer.sv
// Top level of the boot-strap reset sequencer with its result register.
// Each input transaction is one millisecond tick carrying five active-low pin
// levels; each tick yields exactly one result transaction with the enable and
// strap line levels, a one-tick request code and a busy flag. A tick is
// processed in the cycle it is accepted and its result sits in the output
// register the next cycle, so the block takes one tick per clock cycle as long
// as the result side keeps up; the single output register is the only
// buffering, and input ready drops only while that register is full and not
// being taken. Configuration registers reset to their documented defaults and
// are written through a plain write port; writes to an index past the last
// register are ignored.
`default_nettype none

module boot_strap_reset_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire bss_pkg::in_data_t           in_data,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output bss_pkg::out_data_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [bss_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bss_pkg::TickW-1:0]   cfg_wdata
);

  bss_pkg::cfg_t      cfg;
  bss_pkg::out_data_t res;
  bss_pkg::out_data_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               step;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  bss_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bss_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pins_in (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: test/boot_strap_reset_sequencer_tb.sv
// Self-checking testbench for the boot-strap reset sequencer, with a tick-level predictor.
module boot_strap_reset_sequencer_tb;
  import bss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEBOUNCE,
    ST_BOOT_EN_LOW,
    ST_BOOT_HOLD,
    ST_BOOT_AFTER,
    ST_RELEASE_WAIT,
    ST_NORM_EN_LOW,
    ST_SETTLE
  } seq_state_t;

  localparam int unsigned NumRegs = 7;
  // Index past the register list; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_data_t in_data = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  out_data_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_POLL;
  logic [TickW-1:0] cfg_wdata = '0;

  // Predictor state.
  logic [TickW-1:0] tick_limit [NumRegs];
  logic [3:0] seen_levels;
  logic [NumChan-1:0] marked;
  seq_state_t seq_state;
  logic [TickW-1:0] seq_ticks;
  logic en_line;
  logic strap_line;

  out_data_t line_forecast [$];
  int mismatches = 0;
  bit steady_flow = 1'b0;

  // Random pin generator state, bit order as in the pending mask.
  logic [NumChan-1:0] pin_lv = '1;
  int pin_left [NumChan];

  boot_strap_reset_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit waited(reg_idx_t r);
    logic [TickW-1:0] lim;
    lim = (tick_limit[r] == '0) ? TickW'(1) : tick_limit[r];
    return seq_ticks >= lim;
  endfunction

  function automatic logic [ChanW-1:0] first_marked();
    for (int i = 0; i < NumChan; i++)
      if (marked[i]) return ChanW'(i);
    return ChOta;
  endfunction

  function automatic void retire_channel();
    marked[first_marked()] = 1'b0;
    seq_ticks = '0;
    seq_state = (marked != '0) ? ST_DEBOUNCE : ST_IDLE;
  endfunction

  function automatic void check_boot_release(logic boot);
    seq_ticks = '0;
    if (!boot) begin
      seq_state = ST_RELEASE_WAIT;
    end else begin
      en_line = 1'b0;
      seq_state = ST_NORM_EN_LOW;
    end
  endfunction

  // Advances the sequencer by one tick; returns line levels, request code and busy flag.
  function automatic out_data_t predict_lines(in_data_t p);
    logic [NumChan-1:0] pin;
    logic [3:0] now_lv;
    logic [3:0] fell;
    logic [ChanW-1:0] ch;
    req_code_t code;
    out_data_t r;
    pin = '1;
    pin[ChOta] = p.ota_pin;
    pin[ChFactory] = p.factory_pin;
    pin[ChProv] = p.prov_pin;
    pin[ChBoot] = p.boot_pin;
    pin[ChSelfOta] = p.self_ota_pin;
    code = REQ_NONE;
    if (seq_ticks != TickMax) seq_ticks++;
    case (seq_state)
      ST_DEBOUNCE: begin
        if (waited(REG_DEBOUNCE)) begin
          ch = first_marked();
          seq_ticks = '0;
          if (!pin[ch] && ch == ChBoot) begin
            en_line = 1'b0;
            seq_state = ST_BOOT_EN_LOW;
          end else begin
            if (!pin[ch]) begin
              case (ch)
                ChOta: code = REQ_OTA;
                ChFactory: code = REQ_FACTORY;
                ChProv: code = REQ_PROV;
                ChSelfOta: code = REQ_SELF_OTA;
                default: code = REQ_NONE;
              endcase
            end
            retire_channel();
          end
        end
      end
      ST_BOOT_EN_LOW: begin
        if (waited(REG_EN_LOW)) begin
          strap_line = 1'b0;
          seq_ticks = '0;
          seq_state = ST_BOOT_HOLD;
        end
      end
      ST_BOOT_HOLD: begin
        if (waited(REG_STRAP_HOLD)) begin
          en_line = 1'b1;
          seq_ticks = '0;
          seq_state = ST_BOOT_AFTER;
        end
      end
      ST_BOOT_AFTER: begin
        if (waited(REG_STRAP_AFTER)) begin
          strap_line = 1'b1;
          check_boot_release(pin[ChBoot]);
        end
      end
      ST_RELEASE_WAIT: begin
        if (waited(REG_RELEASE_POLL)) check_boot_release(pin[ChBoot]);
      end
      ST_NORM_EN_LOW: begin
        if (waited(REG_EN_LOW)) begin
          strap_line = 1'b1;
          en_line = 1'b1;
          seq_ticks = '0;
          seq_state = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (waited(REG_SETTLE)) retire_channel();
      end
      default: begin
        seq_state = ST_IDLE;
        if (waited(REG_POLL)) begin
          // Mode pins are edge-marked, the boot pin is level-marked.
          now_lv = {pin[ChSelfOta], pin[ChProv], pin[ChFactory], pin[ChOta]};
          fell = seen_levels & ~now_lv;
          marked = marked | {fell[3], 1'b0, fell[2:0]};
          if (!pin[ChBoot]) marked[ChBoot] = 1'b1;
          seen_levels = now_lv;
          seq_ticks = '0;
          if (marked != '0) seq_state = ST_DEBOUNCE;
        end
      end
    endcase
    r.enable_out = en_line;
    r.strap_out = strap_line;
    r.request_code = code;
    r.busy_res = (seq_state != ST_IDLE);
    return r;
  endfunction

  function automatic logic [TickW-1:0] pick_ticks();
    if ($urandom_range(7, 0) == 0) return TickW'($urandom_range(40, 7));
    return TickW'($urandom_range(6, 0));
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NumRegs) tick_limit[idx] = val;
  endtask

  task automatic set_timing(logic [TickW-1:0] poll, logic [TickW-1:0] deb,
                            logic [TickW-1:0] en_low, logic [TickW-1:0] hold,
                            logic [TickW-1:0] after, logic [TickW-1:0] rel,
                            logic [TickW-1:0] settle);
    write_reg(REG_POLL, poll);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_EN_LOW, en_low);
    write_reg(REG_STRAP_HOLD, hold);
    write_reg(REG_STRAP_AFTER, after);
    write_reg(REG_RELEASE_POLL, rel);
    write_reg(REG_SETTLE, settle);
    cfg_we <= 1'b0;
  endtask

  // Valid stays high from one transaction to the next unless a gap is drawn.
  task automatic send_tick(logic [NumChan-1:0] lv);
    in_data_t d;
    while (!steady_flow && $urandom_range(99, 0) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    d.ota_pin = lv[ChOta];
    d.factory_pin = lv[ChFactory];
    d.prov_pin = lv[ChProv];
    d.boot_pin = lv[ChBoot];
    d.self_ota_pin = lv[ChSelfOta];
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_forecast.push_back(predict_lines(d));
  endtask

  task automatic hold_pins(logic [NumChan-1:0] lv, int n);
    repeat (n) send_tick(lv);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_forecast.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // Slave update and factory pins held low: both requests at default timing.
    hold_pins(5'b11100, 152);
    hold_pins('1, 4);
    wait_results_drained();
  endtask

  task automatic test_directed();
    write_reg(RegUnused, '1);
    set_timing(10'd1, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    hold_pins('1, 3);
    // Every channel at once: three requests, then the boot sequence with the
    // boot pin still held when the strap is released.
    hold_pins('0, 10);
    // Boot pin released while the self update pin is still low.
    hold_pins(5'b01000, 8);
    hold_pins('1, 2);
    // A pin that goes high again before its resample gives no request.
    hold_pins(5'b11110, 1);
    hold_pins('1, 3);
    wait_results_drained();
  endtask

  task automatic test_extremes();
    // Zero intervals act as one tick, so the boot sequence steps every tick
    // and the release check repeats until the boot pin goes high.
    set_timing('0, '0, '0, '0, '0, '0, '0);
    hold_pins(5'b10111, 12);
    hold_pins('1, 8);
    wait_results_drained();
  endtask

  task automatic run_random_ticks(int n);
    logic [NumChan-1:0] lv;
    int span;
    int pause_at;
    span = tick_limit[REG_POLL] + tick_limit[REG_DEBOUNCE] + 2;
    pause_at = $urandom_range(n - 1, 1);
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < NumChan; c++) begin
        if (pin_left[c] <= 0) begin
          pin_lv[c] = ($urandom_range(99, 0) < ((c == ChBoot) ? 20 : 40)) ? 1'b0 : 1'b1;
          pin_left[c] = $urandom_range(3 * span, 1);
        end
        pin_left[c]--;
      end
      lv = pin_lv;
      // Occasional one-tick glitch on a random pin.
      if ($urandom_range(99, 0) < 5) lv[$urandom_range(NumChan - 1, 0)] ^= 1'b1;
      send_tick(lv);
      if (k == pause_at) wait_results_drained();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      steady_flow = (ph == 2);
      set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                 pick_ticks(), pick_ticks(), pick_ticks());
      run_random_ticks(50);
      wait_results_drained();
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk)
    out_ready <= steady_flow || ($urandom_range(99, 0) >= 10);

  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_forecast.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatches++;
      end else begin
        want = line_forecast.pop_front();
        if (out_data.enable_out !== want.enable_out) begin
          $error("enable_out: expected %0d, got %0d", want.enable_out, out_data.enable_out);
          mismatches++;
        end
        if (out_data.strap_out !== want.strap_out) begin
          $error("strap_out: expected %0d, got %0d", want.strap_out, out_data.strap_out);
          mismatches++;
        end
        if (out_data.request_code !== want.request_code) begin
          $error("request_code: expected %0d, got %0d", want.request_code,
                 out_data.request_code);
          mismatches++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    tick_limit[REG_POLL] = PollDefault;
    tick_limit[REG_DEBOUNCE] = DebounceDefault;
    tick_limit[REG_EN_LOW] = EnLowDefault;
    tick_limit[REG_STRAP_HOLD] = StrapHoldDefault;
    tick_limit[REG_STRAP_AFTER] = StrapAfterDefault;
    tick_limit[REG_RELEASE_POLL] = ReleasePollDefault;
    tick_limit[REG_SETTLE] = SettleDefault;
    seen_levels = '1;
    marked = '0;
    seq_state = ST_IDLE;
    seq_ticks = '0;
    en_line = 1'b1;
    strap_line = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_extremes();
    test_random();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && line_forecast.size() == 0) begin
      $display("boot_strap_reset_sequencer regression: pass");
    end else begin
      $display("boot_strap_reset_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("boot_strap_reset_sequencer regression: fail");
    $finish;
  end

endmodule
